FILE: rtl/per_source_packet_rate_limiter_core_assert.svh
// Assertion macros shared by the rate limiter RTL.
// Expects signals named clk and arst_n in the including scope.
`ifndef PER_SOURCE_PACKET_RATE_LIMITER_CORE_ASSERT_SVH
`define PER_SOURCE_PACKET_RATE_LIMITER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PSRL_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSRL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/psrl_pkg.sv
// Package for the per-source packet rate limiter: sizes, codes and record types.
// Used by the core and psrl_flow_cell among the RTL files; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package psrl_pkg;
	localparam int FLOW_ENTRIES  = 64;
	localparam int WHITE_ENTRIES = 64;
	localparam int FLOW_W        = $clog2(FLOW_ENTRIES);

	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

	localparam logic [31:0] PACKET_LIMIT_RST = 32'd10000;
	localparam logic [39:0] BYTE_LIMIT_RST   = 40'd104857600;
	localparam logic [63:0] WINDOW_LEN_RST   = 64'd1000000000;

	localparam logic [1:0] CFG_PACKET_LIMIT = 2'd0;
	localparam logic [1:0] CFG_BYTE_LIMIT   = 2'd1;
	localparam logic [1:0] CFG_WINDOW_LEN   = 2'd2;

	localparam logic [3:0] CAUSE_NOT_IPV4   = 4'd0;
	localparam logic [3:0] CAUSE_TRUNCATED  = 4'd1;
	localparam logic [3:0] CAUSE_WHITE      = 4'd2;
	localparam logic [3:0] CAUSE_NEW_SRC    = 4'd3;
	localparam logic [3:0] CAUSE_RESTART    = 4'd4;
	localparam logic [3:0] CAUSE_WITHIN     = 4'd5;
	localparam logic [3:0] CAUSE_OVER       = 4'd6;
	localparam logic [3:0] CAUSE_LISTED     = 4'd7;
	localparam logic [3:0] CAUSE_LIST_FULL  = 4'd8;
	localparam logic [3:0] CAUSE_ALREADY    = 4'd9;

	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] packets;
		logic [40:0] bytes;
		logic [63:0] start;
		logic [31:0] drops;
	} flow_rec_t;

	typedef struct packed {
		logic              wr_en;
		logic              touch_en;
		logic [FLOW_W-1:0] touch_rank;
		flow_rec_t         wr;
	} flow_ctl_t;

	typedef struct packed {
		logic hit;
		logic first_free;
		logic oldest;
	} flow_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_UPD  = 3'b100
	} state_t;
endpackage
`default_nettype wire

FILE: rtl/psrl_req_if.sv
// Request channel of the rate limiter: valid/ready plus the descriptor fields.
// Standalone interface, no dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface psrl_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic        eth_whole;
	logic [15:0] ether_type;
	logic        ip_whole;
	logic [31:0] source_addr;
	logic [15:0] frame_len;
	logic [63:0] now_ns;

	modport source (output valid, mode, eth_whole, ether_type, ip_whole, source_addr,
		frame_len, now_ns, input ready);
	modport sink (input valid, mode, eth_whole, ether_type, ip_whole, source_addr,
		frame_len, now_ns, output ready);
endinterface
`default_nettype wire

FILE: rtl/psrl_resp_if.sv
// Response channel of the rate limiter: valid/ready plus the verdict fields.
// Standalone interface, no dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface psrl_resp_if;
	logic        valid;
	logic        ready;
	logic        drop;
	logic [3:0]  cause;
	logic [31:0] drop_count;

	modport source (output valid, drop, cause, drop_count, input ready);
	modport sink (input valid, drop, cause, drop_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/per_source_packet_rate_limiter_core.sv
// Top level of the per-source packet rate limiter: control, config and cell rows.
// Depends on psrl_pkg, psrl_req_if, psrl_resp_if, psrl_flow_cell, psrl_white_cell
// and the assertion header.
//
// Usage: packet descriptors and whitelist additions enter on the req channel;
// one verdict per request leaves on the resp channel (drop, cause, drop_count).
// Both channels use valid/ready; a request moves when both are high.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data) with
// index 0 packet limit, 1 byte limit, 2 window length; other indexes are ignored.
// Each request passes through capture, a lookup cycle in which every cell
// compares its address with the source and the first-free chain settles, and
// an update cycle that writes the chosen cell and reorders the LRU ranks.
// The verdict appears in the output register at the end of the update cycle,
// and a new request is taken only after the previous one has left the update cycle;
// the one shared window subtract and limit compare in the update cycle, and
// the rank update that must finish before the next lookup, are the reason.
// The next request is taken while a verdict still waits in the output register.
// If the receiver stalls with a verdict pending, the update cycle waits.
// Reset clears all valid bits, restores the default limits and sets the LRU
// ranks to entry index order; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "per_source_packet_rate_limiter_core_assert.svh"
module per_source_packet_rate_limiter_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	psrl_req_if.sink         req,
	psrl_resp_if.source      resp,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	localparam int N  = psrl_pkg::FLOW_ENTRIES;
	localparam int NW = psrl_pkg::WHITE_ENTRIES;
	localparam int W  = psrl_pkg::FLOW_W;

	// Configuration registers.
	logic [31:0] packet_limit_q;
	logic [39:0] byte_limit_q;
	logic [63:0] window_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_limit_q <= psrl_pkg::PACKET_LIMIT_RST;
			byte_limit_q   <= psrl_pkg::BYTE_LIMIT_RST;
			window_len_q   <= psrl_pkg::WINDOW_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				psrl_pkg::CFG_PACKET_LIMIT: packet_limit_q <= cfg_data[31:0];
				psrl_pkg::CFG_BYTE_LIMIT:   byte_limit_q   <= cfg_data[39:0];
				psrl_pkg::CFG_WINDOW_LEN:   window_len_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Captured request.
	logic        mode_q;
	logic        eth_whole_q;
	logic [15:0] ether_type_q;
	logic        ip_whole_q;
	logic [31:0] src_q;
	logic [15:0] len_q;
	logic [63:0] now_q;

	psrl_pkg::state_t state_q;
	logic             out_valid_q;
	logic             out_drop_q;
	logic [3:0]       out_cause_q;
	logic [31:0]      out_count_q;

	logic in_fire;
	logic upd_go;

	assign req.ready = (state_q == psrl_pkg::ST_IDLE);
	assign in_fire   = req.valid && req.ready;
	assign upd_go    = (state_q == psrl_pkg::ST_UPD) && (!out_valid_q || resp.ready);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q       <= req.mode;
			eth_whole_q  <= req.eth_whole;
			ether_type_q <= req.ether_type;
			ip_whole_q   <= req.ip_whole;
			src_q        <= req.source_addr;
			len_q        <= req.frame_len;
			now_q        <= req.now_ns;
		end
	end

	// Cell rows.
	psrl_pkg::flow_stat_t flow_stat [N];
	psrl_pkg::flow_rec_t  flow_rec  [N];
	logic [W-1:0]         flow_rank [N];
	logic [N:0]           flow_taken;
	logic [N-1:0]         flow_sel_s1;
	psrl_pkg::flow_ctl_t  flow_ctl;

	logic [NW:0]   white_taken;
	logic [NW-1:0] white_hit;
	logic [NW-1:0] white_first;
	logic [NW-1:0] white_sel_s1;
	logic          white_wr;

	assign flow_taken[0]  = 1'b0;
	assign white_taken[0] = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_flow
		psrl_flow_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (W'(i)),
			.src       (src_q),
			.taken_in  (flow_taken[i]),
			.taken_out (flow_taken[i+1]),
			.stat      (flow_stat[i]),
			.sel       (flow_sel_s1[i]),
			.ctl       (flow_ctl),
			.rec       (flow_rec[i]),
			.rank      (flow_rank[i])
		);
	end

	for (genvar i = 0; i < NW; i++) begin : g_white
		psrl_white_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.src        (src_q),
			.taken_in   (white_taken[i]),
			.taken_out  (white_taken[i+1]),
			.hit        (white_hit[i]),
			.first_free (white_first[i]),
			.wr_en      (white_wr && white_sel_s1[i])
		);
	end

	// Lookup: pick the target entry (hit, else first free, else oldest)
	// and gather its record and rank.
	logic [N-1:0]        hit_vec;
	logic [N-1:0]        free_vec;
	logic [N-1:0]        old_vec;
	logic [N-1:0]        tgt_vec;
	psrl_pkg::flow_rec_t tgt_rec;
	logic [W-1:0]        tgt_rank;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			hit_vec[i]  = flow_stat[i].hit;
			free_vec[i] = flow_stat[i].first_free;
			old_vec[i]  = flow_stat[i].oldest;
		end
		if (|hit_vec) begin
			tgt_vec = hit_vec;
		end else if (|free_vec) begin
			tgt_vec = free_vec;
		end else begin
			tgt_vec = old_vec;
		end
		tgt_rec  = '0;
		tgt_rank = '0;
		for (int i = 0; i < N; i++) begin
			tgt_rec  = tgt_rec | (flow_rec[i] & {$bits(psrl_pkg::flow_rec_t){tgt_vec[i]}});
			tgt_rank = tgt_rank | (flow_rank[i] & {W{tgt_vec[i]}});
		end
	end

	logic                flow_hit_s1;
	logic                white_hit_s1;
	logic                white_full_s1;
	psrl_pkg::flow_rec_t rec_s1;
	logic [W-1:0]        rank_s1;

	always_ff @(posedge clk) begin
		if (state_q == psrl_pkg::ST_LOOK) begin
			flow_sel_s1   <= tgt_vec;
			flow_hit_s1   <= |hit_vec;
			rec_s1        <= tgt_rec;
			rank_s1       <= tgt_rank;
			white_sel_s1  <= white_first;
			white_hit_s1  <= |white_hit;
			white_full_s1 <= !white_taken[NW];
		end
	end

	// Update: verdict, whitelist or record write and LRU reorder.
	logic        drop_d;
	logic [3:0]  cause_d;
	logic [31:0] count_d;
	logic [63:0] elapsed;
	logic        is_flow;

	assign elapsed = now_q - rec_s1.start;

	always_comb begin
		drop_d   = 1'b0;
		cause_d  = psrl_pkg::CAUSE_NOT_IPV4;
		count_d  = '0;
		white_wr = 1'b0;
		is_flow  = 1'b0;
		flow_ctl = '0;
		flow_ctl.touch_rank = rank_s1;
		flow_ctl.wr         = rec_s1;
		if (mode_q) begin
			if (white_hit_s1) begin
				cause_d = psrl_pkg::CAUSE_ALREADY;
			end else if (white_full_s1) begin
				cause_d = psrl_pkg::CAUSE_LIST_FULL;
			end else begin
				cause_d  = psrl_pkg::CAUSE_LISTED;
				white_wr = upd_go;
			end
		end else if (!eth_whole_q) begin
			drop_d  = 1'b1;
			cause_d = psrl_pkg::CAUSE_TRUNCATED;
		end else if (ether_type_q != psrl_pkg::ETYPE_IPV4) begin
			cause_d = psrl_pkg::CAUSE_NOT_IPV4;
		end else if (!ip_whole_q) begin
			drop_d  = 1'b1;
			cause_d = psrl_pkg::CAUSE_TRUNCATED;
		end else if (white_hit_s1) begin
			cause_d = psrl_pkg::CAUSE_WHITE;
		end else begin
			is_flow = 1'b1;
			if (!flow_hit_s1) begin
				cause_d             = psrl_pkg::CAUSE_NEW_SRC;
				flow_ctl.wr.addr    = src_q;
				flow_ctl.wr.packets = 32'd1;
				flow_ctl.wr.bytes   = {25'd0, len_q};
				flow_ctl.wr.start   = now_q;
				flow_ctl.wr.drops   = '0;
			end else if (elapsed > window_len_q) begin
				cause_d             = psrl_pkg::CAUSE_RESTART;
				count_d             = rec_s1.drops;
				flow_ctl.wr.packets = 32'd1;
				flow_ctl.wr.bytes   = {25'd0, len_q};
				flow_ctl.wr.start   = now_q;
			end else if (rec_s1.packets >= packet_limit_q ||
				rec_s1.bytes >= {1'b0, byte_limit_q}) begin
				drop_d  = 1'b1;
				cause_d = psrl_pkg::CAUSE_OVER;
				if (rec_s1.drops != 32'hFFFF_FFFF) begin
					flow_ctl.wr.drops = rec_s1.drops + 32'd1;
				end
				count_d = flow_ctl.wr.drops;
			end else begin
				cause_d             = psrl_pkg::CAUSE_WITHIN;
				count_d             = rec_s1.drops;
				flow_ctl.wr.packets = rec_s1.packets + 32'd1;
				flow_ctl.wr.bytes   = rec_s1.bytes + {25'd0, len_q};
			end
		end
		flow_ctl.wr_en    = upd_go && is_flow;
		flow_ctl.touch_en = upd_go && is_flow;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= psrl_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				psrl_pkg::ST_IDLE: if (in_fire) state_q <= psrl_pkg::ST_LOOK;
				psrl_pkg::ST_LOOK: state_q <= psrl_pkg::ST_UPD;
				psrl_pkg::ST_UPD:  if (upd_go) state_q <= psrl_pkg::ST_IDLE;
				default:           state_q <= psrl_pkg::ST_IDLE;
			endcase
			if (upd_go) begin
				out_valid_q <= 1'b1;
			end else if (resp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			out_drop_q  <= drop_d;
			out_cause_q <= cause_d;
			out_count_q <= count_d;
		end
	end

	assign resp.valid      = out_valid_q;
	assign resp.drop       = out_drop_q;
	assign resp.cause      = out_cause_q;
	assign resp.drop_count = out_count_q;

	// Addresses in the flow table stay unique, so at most one cell matches.
	`PSRL_ASSERT_IMPL(a_hit_unique, state_q == psrl_pkg::ST_LOOK, $onehot0(hit_vec), "multiple flow hits")
	// The update always addresses exactly one flow cell.
	`PSRL_ASSERT_IMPL(a_tgt_onehot, state_q == psrl_pkg::ST_UPD, $onehot(flow_sel_s1), "flow target not one-hot")
	// A completed update leaves a verdict waiting in the output register.
	`PSRL_ASSERT_NEXT(a_upd_out, upd_go, out_valid_q && state_q == psrl_pkg::ST_IDLE, "verdict lost")
	// Exactly one entry always carries the oldest rank, whether or not the table is full.
	`PSRL_ASSERT_IMPL(a_old_onehot, state_q == psrl_pkg::ST_LOOK, $onehot(old_vec), "LRU ranks broken")
endmodule
`default_nettype wire

FILE: rtl/psrl_white_cell.sv
// One whitelist entry: address, valid bit, match and first-free chain link.
// Standalone module, no dependencies.
`timescale 1ns / 1ps
`default_nettype none
module psrl_white_cell (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] src,
	input  wire logic        taken_in,
	output logic             taken_out,
	output logic             hit,
	output logic             first_free,
	input  wire logic        wr_en
);
	logic [31:0] addr_q;
	logic        valid_q;

	assign hit        = valid_q && (addr_q == src);
	assign first_free = !valid_q && !taken_in;
	assign taken_out  = taken_in || !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			addr_q <= src;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/psrl_flow_cell.sv
// One flow table entry: address, counters, window start, drops and LRU rank.
// Depends on psrl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psrl_flow_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [psrl_pkg::FLOW_W-1:0] idx,
	input  wire logic [31:0]               src,
	input  wire logic                      taken_in,
	output logic                           taken_out,
	output psrl_pkg::flow_stat_t           stat,
	input  wire logic                      sel,
	input  wire psrl_pkg::flow_ctl_t       ctl,
	output psrl_pkg::flow_rec_t            rec,
	output logic [psrl_pkg::FLOW_W-1:0]    rank
);
	psrl_pkg::flow_rec_t             rec_q;
	logic                            valid_q;
	logic [psrl_pkg::FLOW_W-1:0]     rank_q;

	assign stat.hit        = valid_q && (rec_q.addr == src);
	assign stat.first_free = !valid_q && !taken_in;
	assign stat.oldest     = (rank_q == psrl_pkg::FLOW_W'(psrl_pkg::FLOW_ENTRIES - 1));
	assign taken_out       = taken_in || !valid_q;
	assign rec             = rec_q;
	assign rank            = rank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= idx;
		end else begin
			if (ctl.wr_en && sel) begin
				valid_q <= 1'b1;
			end
			// Move to the front; entries that were more recent age by one.
			if (ctl.touch_en) begin
				if (sel) begin
					rank_q <= '0;
				end else if (rank_q < ctl.touch_rank) begin
					rank_q <= rank_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en && sel) begin
			rec_q <= ctl.wr;
		end
	end
endmodule
`default_nettype wire

FILE: verif/psrl_checker.sv
// Verdict checker for the rate limiter: watches the request, verdict and config ports,
// predicts each verdict and compares it. Depends on psrl_pkg and the two channel interfaces.
`timescale 1ns / 1ps
module psrl_checker
	import psrl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	psrl_req_if         req,
	psrl_resp_if        resp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          fail_count,
	output int          verdicts_owed
);
	typedef struct packed {
		logic        drop;
		logic [3:0]  cause;
		logic [31:0] drop_count;
	} verdict_t;

	logic [31:0] lim_packets;
	logic [39:0] lim_bytes;
	logic [63:0] win_len;

	logic [31:0] wl_addr [WHITE_ENTRIES];
	logic        wl_used [WHITE_ENTRIES];
	logic [31:0] fl_addr [FLOW_ENTRIES];
	logic        fl_used [FLOW_ENTRIES];
	logic [31:0] fl_pkts [FLOW_ENTRIES];
	logic [40:0] fl_bytes [FLOW_ENTRIES];
	logic [63:0] fl_start [FLOW_ENTRIES];
	logic [31:0] fl_drops [FLOW_ENTRIES];
	int          fl_age [FLOW_ENTRIES];

	verdict_t owed_verdicts[$];

	assign verdicts_owed = owed_verdicts.size();

	function automatic void promote_flow(int e);
		int r;
		r = fl_age[e];
		for (int i = 0; i < FLOW_ENTRIES; i++)
			if (fl_age[i] < r) fl_age[i]++;
		fl_age[e] = 0;
	endfunction

	// Applies one request to the shadow tables and returns the verdict it earns.
	function automatic verdict_t judge_request(logic mode, logic eth_ok, logic [15:0] etype,
			logic ip_ok, logic [31:0] src, logic [15:0] len, logic [63:0] now);
		int free_w, hit, victim;
		verdict_t v;
		free_w = -1;
		hit = -1;
		victim = -1;
		v = '0;
		if (mode) begin
			for (int i = 0; i < WHITE_ENTRIES; i++) begin
				if (wl_used[i] && wl_addr[i] == src) begin
					v.cause = CAUSE_ALREADY;
					return v;
				end
				if (!wl_used[i] && free_w < 0) free_w = i;
			end
			if (free_w < 0) begin
				v.cause = CAUSE_LIST_FULL;
				return v;
			end
			wl_addr[free_w] = src;
			wl_used[free_w] = 1'b1;
			v.cause = CAUSE_LISTED;
			return v;
		end
		if (!eth_ok || (etype == ETYPE_IPV4 && !ip_ok)) begin
			v.drop = 1'b1;
			v.cause = CAUSE_TRUNCATED;
			return v;
		end
		if (etype != ETYPE_IPV4) begin
			v.cause = CAUSE_NOT_IPV4;
			return v;
		end
		for (int i = 0; i < WHITE_ENTRIES; i++)
			if (wl_used[i] && wl_addr[i] == src) begin
				v.cause = CAUSE_WHITE;
				return v;
			end
		for (int i = 0; i < FLOW_ENTRIES; i++) begin
			if (fl_used[i] && fl_addr[i] == src && hit < 0) hit = i;
			if (!fl_used[i] && victim < 0) victim = i;
		end
		if (hit < 0) begin
			if (victim < 0) begin
				victim = 0;
				for (int i = 0; i < FLOW_ENTRIES; i++)
					if (fl_age[i] >= fl_age[victim]) victim = i;
			end
			fl_used[victim] = 1'b1;
			fl_addr[victim] = src;
			fl_pkts[victim] = 32'd1;
			fl_bytes[victim] = {25'd0, len};
			fl_start[victim] = now;
			fl_drops[victim] = '0;
			promote_flow(victim);
			v.cause = CAUSE_NEW_SRC;
			return v;
		end
		promote_flow(hit);
		if (now - fl_start[hit] > win_len) begin
			fl_pkts[hit] = 32'd1;
			fl_bytes[hit] = {25'd0, len};
			fl_start[hit] = now;
			v.cause = CAUSE_RESTART;
			v.drop_count = fl_drops[hit];
			return v;
		end
		if (fl_pkts[hit] >= lim_packets || fl_bytes[hit] >= {1'b0, lim_bytes}) begin
			if (fl_drops[hit] != 32'hFFFF_FFFF) fl_drops[hit]++;
			v.drop = 1'b1;
			v.cause = CAUSE_OVER;
			v.drop_count = fl_drops[hit];
			return v;
		end
		fl_pkts[hit]++;
		fl_bytes[hit] = fl_bytes[hit] + len;
		v.cause = CAUSE_WITHIN;
		v.drop_count = fl_drops[hit];
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			lim_packets = PACKET_LIMIT_RST;
			lim_bytes = BYTE_LIMIT_RST;
			win_len = WINDOW_LEN_RST;
			for (int i = 0; i < WHITE_ENTRIES; i++) wl_used[i] = 1'b0;
			for (int i = 0; i < FLOW_ENTRIES; i++) begin
				fl_used[i] = 1'b0;
				fl_age[i] = i;
			end
			owed_verdicts.delete();
			fail_count = 0;
		end else begin
			if (resp.valid && resp.ready) begin
				if (owed_verdicts.size() == 0) begin
					$error("verdict with none expected: drop %0d cause %0d count %0d",
						resp.drop, resp.cause, resp.drop_count);
					fail_count++;
				end else begin
					want = owed_verdicts.pop_front();
					if (resp.drop !== want.drop) begin
						$error("drop: expected %0d, got %0d", want.drop, resp.drop);
						fail_count++;
					end
					if (resp.cause !== want.cause) begin
						$error("cause: expected %0d, got %0d", want.cause, resp.cause);
						fail_count++;
					end
					if (resp.drop_count !== want.drop_count) begin
						$error("drop_count: expected %0d, got %0d", want.drop_count,
							resp.drop_count);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				owed_verdicts.push_back(judge_request(req.mode, req.eth_whole,
					req.ether_type, req.ip_whole, req.source_addr, req.frame_len,
					req.now_ns));
			if (cfg_we) begin
				case (cfg_index)
					CFG_PACKET_LIMIT: lim_packets = cfg_data[31:0];
					CFG_BYTE_LIMIT:   lim_bytes = cfg_data[39:0];
					CFG_WINDOW_LEN:   win_len = cfg_data;
					default: ;
				endcase
			end
		end
	end
endmodule

FILE: verif/tb_top.sv
// Top of the rate limiter testbench: clock, reset, request and config stimulus, verdict.
// Depends on psrl_pkg, the channel interfaces, the core and psrl_checker.
`timescale 1ns / 1ps
module tb_top;
	import psrl_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	int          fail_count;
	int          verdicts_owed;

	psrl_req_if  req ();
	psrl_resp_if resp ();

	per_source_packet_rate_limiter_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req.sink),
		.resp      (resp.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	psrl_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.resp          (resp),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.verdicts_owed (verdicts_owed)
	);

	// Source addresses used by the stimulus. A small hot set gives table hits and
	// limit hits; drawing from the whole pool overflows the 64-entry flow table,
	// which forces evictions of the least recently used source.
	localparam int POOL_SIZE = 96;
	logic [31:0] src_pool [POOL_SIZE];

	// Running time stamp; it advances between requests by a step that is scaled
	// to the current window so that windows both expire and stay open.
	logic [63:0] clock_ns;
	int          burst_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The run is expected to take well under a tenth of this.
	initial begin
		#20ms;
		$display("tb_top: done, errors");
		$finish;
	end

	// The receiver stalls on a pattern of its own: it switches at random between
	// always ready, a coin flip every cycle, and long stalls with rare ready cycles.
	initial begin
		int style;
		int style_left;
		resp.ready = 1'b0;
		style = 0;
		style_left = 0;
		forever begin
			@(negedge clk);
			if (style_left == 0) begin
				style = $urandom_range(0, 2);
				style_left = $urandom_range(5, 60);
			end
			style_left--;
			case (style)
				0: resp.ready <= 1'b1;
				1: resp.ready <= $urandom_range(0, 1);
				default: resp.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Drives one request at the falling edge and holds it until it is accepted.
	// Between requests the sender keeps valid high inside a burst, and drops it
	// for a random gap once the burst is used up.
	task automatic send_request(logic mode, logic eth_ok, logic [15:0] etype, logic ip_ok,
			logic [31:0] src, logic [15:0] len, logic [63:0] now);
		logic taken;
		if (burst_left == 0) begin
			req.valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		req.valid = 1'b1;
		req.mode = mode;
		req.eth_whole = eth_ok;
		req.ether_type = etype;
		req.ip_whole = ip_ok;
		req.source_addr = src;
		req.frame_len = len;
		req.now_ns = now;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = req.ready;
		end
		burst_left--;
		@(negedge clk);
		if (burst_left == 0) req.valid = 1'b0;
	endtask

	// Parks the sender until every verdict has come back, by which point the core is
	// back in idle, and then lets the clock run on before anything else happens.
	task automatic drain_all();
		req.valid = 1'b0;
		burst_left = 0;
		while (verdicts_owed != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_register(logic [1:0] index, logic [63:0] value);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_data = '0;
	endtask

	task automatic set_limits(logic [31:0] packets, logic [39:0] bytes, logic [63:0] window);
		drain_all();
		write_register(CFG_PACKET_LIMIT, {32'd0, packets});
		write_register(CFG_BYTE_LIMIT, {24'd0, bytes});
		write_register(CFG_WINDOW_LEN, window);
	endtask

	// Mostly well-formed IPv4 descriptors from the pool; the rest are whitelist
	// additions and malformed or non-IPv4 frames with random fields.
	task automatic random_requests(int count, int hot_size, logic [63:0] max_step);
		int kind;
		logic [31:0] src;
		logic [15:0] len;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(0, 99);
			src = src_pool[$urandom_range(0, ($urandom_range(0, 3) == 0) ?
				POOL_SIZE - 1 : hot_size - 1)];
			len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(40, 1500));
			if ($urandom_range(0, 49) == 0)
				clock_ns = {$urandom, $urandom};
			else
				clock_ns = clock_ns + (64'($urandom) % (max_step + 1));
			if (kind < 4)
				send_request(1'b1, 1'($urandom), 16'($urandom), 1'($urandom),
					($urandom_range(0, 1) != 0) ? src : $urandom, len, clock_ns);
			else if (kind < 14)
				send_request(1'b0, 1'($urandom), ($urandom_range(0, 1) != 0) ?
					ETYPE_IPV4 : 16'($urandom), 1'($urandom), src, len, clock_ns);
			else
				send_request(1'b0, 1'b1, ETYPE_IPV4, 1'b1, src, len, clock_ns);
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.mode = 1'b0;
		req.eth_whole = 1'b0;
		req.ether_type = '0;
		req.ip_whole = 1'b0;
		req.source_addr = '0;
		req.frame_len = '0;
		req.now_ns = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_PACKET_LIMIT;
		cfg_data = '0;
		burst_left = 0;
		clock_ns = 64'd1000;
		src_pool[0] = 32'h0000_0000;
		src_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++) src_pool[i] = $urandom;

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part under the reset limits: whitelist addition and duplicate,
		// truncated headers (Ethernet truncation wins over a foreign ethertype),
		// non-IPv4, whitelisted source, new sources at the field extremes, a hit
		// inside the window and a hit after the window has run out.
		send_request(1'b1, 1'b0, 16'h0000, 1'b0, src_pool[5], 16'd0, 64'd0);
		send_request(1'b1, 1'b1, 16'hFFFF, 1'b1, src_pool[5], 16'hFFFF, '1);
		send_request(1'b0, 1'b0, 16'h86DD, 1'b1, src_pool[2], 16'd64, 64'd10);
		send_request(1'b0, 1'b0, ETYPE_IPV4, 1'b0, src_pool[2], 16'd64, 64'd10);
		send_request(1'b0, 1'b1, 16'h86DD, 1'b0, src_pool[2], 16'd64, 64'd10);
		send_request(1'b0, 1'b1, 16'hFFFF, 1'b1, src_pool[2], 16'd64, 64'd10);
		send_request(1'b0, 1'b1, ETYPE_IPV4, 1'b0, src_pool[2], 16'd64, 64'd10);
		send_request(1'b0, 1'b1, ETYPE_IPV4, 1'b1, src_pool[5], 16'd64, 64'd20);
		send_request(1'b0, 1'b1, ETYPE_IPV4, 1'b1, src_pool[0], 16'hFFFF, 64'd0);
		send_request(1'b0, 1'b1, ETYPE_IPV4, 1'b1, src_pool[1], 16'd0, '1);
		send_request(1'b0, 1'b1, ETYPE_IPV4, 1'b1, src_pool[0], 16'd100, 64'd500);
		send_request(1'b0, 1'b1, ETYPE_IPV4, 1'b1, src_pool[1], 16'd100, 64'd5);
		send_request(1'b0, 1'b1, ETYPE_IPV4, 1'b1, src_pool[0], 16'd100, 64'd2000000000);
		send_request(1'b0, 1'b1, ETYPE_IPV4, 1'b1, src_pool[0], 16'd100, 64'd2000000001);

		// Tight limits: packet and byte limits bite within a window of a few steps.
		set_limits(32'd3, 40'd2000, 64'd200);
		random_requests(200, 12, 64'd60);

		// Upper extremes: windows never run out, so entries only age and evict.
		set_limits(32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, '1);
		random_requests(120, 70, 64'd1000);

		// Lower extremes: one packet and one byte per window of one nanosecond.
		set_limits(32'd1, 40'd1, 64'd1);
		random_requests(120, 10, 64'd2);

		// A mid-run pause with nothing in flight, then more of the tight setting.
		set_limits(32'd5, 40'd6000, 64'd400);
		random_requests(100, 20, 64'd80);
		drain_all();
		random_requests(60, 20, 64'd80);

		// Fill the whitelist past capacity; pool sources then mostly pass as listed.
		drain_all();
		for (int i = 0; i < 70; i++)
			send_request(1'b1, 1'b1, ETYPE_IPV4, 1'b1,
				(i < 40) ? src_pool[i] : 32'($urandom), 16'd0, clock_ns);
		random_requests(60, 48, 64'd80);

		drain_all();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule

FILE: per_source_packet_rate_limiter_core.f
+incdir+rtl
rtl/psrl_pkg.sv
rtl/psrl_req_if.sv
rtl/psrl_resp_if.sv
rtl/psrl_white_cell.sv
rtl/psrl_flow_cell.sv
rtl/per_source_packet_rate_limiter_core.sv
verif/psrl_checker.sv
verif/tb_top.sv
